>>> rtl/tli_pkg.sv
// Shared types, widths and codes for the table linear interpolator.
`timescale 1ns / 1ps

package tli_pkg;

    localparam int VALUE_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 48;
    localparam int IDX_W = 6;
    localparam int CFG_W = 7;
    localparam int CLAMP_W = 2;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_LOW = 2'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd2;

    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   entry_index;
        logic [VALUE_W-1:0] entry_x;
        logic [VALUE_W-1:0] entry_y;
        logic [VALUE_W-1:0] query_x;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] interp_y;
        logic [PROD_W-1:0]  product_xy;
        logic [CLAMP_W-1:0] clamped;
    } out_item_t;

endpackage

>>> rtl/table_linear_interpolator_unit.sv
// Top level: piecewise-linear table interpolator with load and query commands.
`timescale 1ns / 1ps

// A load command (op = 0) writes one (x, y) pair into the table RAM in the cycle it is
// taken and produces no result; busy stays low. A query (op = 1) raises busy until its
// result is shown: the low and high ends are checked first (a clamped query skips to the
// final multiply), then the table is scanned one entry per cycle through the single
// RAM read port, then one 32x32 multiply, a bit-serial division and the final multiply
// follow. An interior query stops its scan at the bracketing entry, at position 1 to
// entries_used - 1. The next item can be taken in the cycle after the result is shown.
// The result is on the result port for exactly one cycle with done high and cannot be
// held off by the receiver. entries_used is written through the cfg channel, which is
// ready whenever no query is in flight.

module table_linear_interpolator_unit #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  tli_pkg::in_item_t         item,
    output logic                      done,
    output tli_pkg::out_item_t        result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tli_pkg::CFG_W-1:0] cfg_data
);

    localparam int V = tli_pkg::VALUE_W;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] ONE_A = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] LAST_MAX = ADDR_W'(TABLE_DEPTH - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_LAST  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_MULT  = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_PROD  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]                   state_reg, state_next;
    logic [ADDR_W-1:0]            last_reg, last_next;
    logic [ADDR_W-1:0]            cur_reg, cur_next;
    logic [V-1:0]                 q_reg, q_next;
    logic [V-1:0]                 x1_reg, x1_next;
    logic [V-1:0]                 y1_reg, y1_next;
    logic [V-1:0]                 dx_reg, dx_next;
    logic [V-1:0]                 dy_reg, dy_next;
    logic [V-1:0]                 t_reg, t_next;
    logic                         down_reg, down_next;
    logic [V-1:0]                 y_reg, y_next;
    logic [tli_pkg::CLAMP_W-1:0]  clamp_reg, clamp_next;
    logic [2*V-1:0]               mul_reg, mul_next;

    logic              take;
    logic [31:0]       idx_wide;
    logic              idx_ok;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [2*V-1:0]    rdata;
    logic [V-1:0]      x_rd;
    logic [V-1:0]      y_rd;
    logic [31:0]       cfg_wide;
    logic [31:0]       cfg_m1;
    logic [V-1:0]      mul_a;
    logic [V-1:0]      mul_b;
    logic [2*V-1:0]    mul_full;
    logic [2*V-1:0]    num;
    logic              div_start;
    logic [V-1:0]      quo;
    logic              div_done;
    logic [V-1:0]      qt;

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign take = start && !busy;

    assign idx_wide = 32'(item.entry_index);
    assign idx_ok = (idx_wide < 32'(TABLE_DEPTH));
    assign we = take && (item.op == tli_pkg::OP_LOAD) && idx_ok;
    assign waddr = idx_wide[ADDR_W-1:0];

    assign x_rd = rdata[2*V-1:V];
    assign y_rd = rdata[V-1:0];

    tli_ram #(
        .WIDTH(2 * V),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata({item.entry_x, item.entry_y}),
        .raddr(raddr),
        .rdata(rdata)
    );

    // one shared multiplier: span product while interpolating, final product after
    assign mul_a = (state_reg == S_MULT) ? t_reg : q_reg;
    assign mul_b = (state_reg == S_MULT) ? dy_reg : y_reg;
    assign mul_full = mul_a * mul_b;

    // round to nearest: add half the span before dividing
    assign num = mul_reg + {{V{1'b0}}, (dx_reg >> 1)};
    assign div_start = (state_reg == S_ADD);

    tli_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (num),
        .den  (dx_reg),
        .quo  (quo),
        .done (div_done)
    );

    assign qt = (quo > dy_reg) ? dy_reg : quo;

    // read address: next entry is requested while the current one is examined
    always_comb
    begin
        case (state_reg)
            S_FIRST: raddr = last_reg;
            S_LAST:  raddr = ONE_A;
            S_SCAN:  raddr = cur_reg + ONE_A;
            default: raddr = '0;
        endcase
    end

    always_comb
    begin
        cfg_wide = 32'(cfg_data);
        cfg_m1 = cfg_wide - 32'd1;

        state_next = state_reg;
        last_next = last_reg;
        cur_next = cur_reg;
        q_next = q_reg;
        x1_next = x1_reg;
        y1_next = y1_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        t_next = t_reg;
        down_next = down_reg;
        y_next = y_reg;
        clamp_next = clamp_reg;
        mul_next = mul_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_wide < 32'd2)
            begin
                last_next = ONE_A;
            end
            else if (cfg_wide > 32'(TABLE_DEPTH))
            begin
                last_next = LAST_MAX;
            end
            else
            begin
                last_next = cfg_m1[ADDR_W-1:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take && (item.op == tli_pkg::OP_QUERY))
                begin
                    q_next = item.query_x;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (q_reg <= x_rd)
                begin
                    y_next = y_rd;
                    clamp_next = tli_pkg::CLAMP_LOW;
                    state_next = S_PROD;
                end
                else
                begin
                    x1_next = x_rd;
                    y1_next = y_rd;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (q_reg >= x_rd)
                begin
                    y_next = y_rd;
                    clamp_next = tli_pkg::CLAMP_HIGH;
                    state_next = S_PROD;
                end
                else
                begin
                    cur_next = ONE_A;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((cur_reg == last_reg) || (x_rd >= q_reg))
                begin
                    // bracketing pair found: previous entry and this one
                    dx_next = x_rd - x1_reg;
                    t_next = q_reg - x1_reg;
                    down_next = (y_rd < y1_reg);
                    dy_next = (y_rd < y1_reg) ? (y1_reg - y_rd) : (y_rd - y1_reg);
                    clamp_next = tli_pkg::CLAMP_NONE;
                    state_next = S_MULT;
                end
                else
                begin
                    x1_next = x_rd;
                    y1_next = y_rd;
                    cur_next = cur_reg + ONE_A;
                end
            end
            S_MULT:
            begin
                mul_next = mul_full;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    y_next = down_reg ? (y1_reg - qt) : (y1_reg + qt);
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                mul_next = mul_full;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg <= ONE_A;
            cur_reg <= ONE_A;
        end
        else
        begin
            state_reg <= state_next;
            last_reg <= last_next;
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        x1_reg <= x1_next;
        y1_reg <= y1_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        t_reg <= t_next;
        down_reg <= down_next;
        y_reg <= y_next;
        clamp_reg <= clamp_next;
        mul_reg <= mul_next;
    end

    // Q16.16 times Q16.16 shifted down by 16 always fits 48 bits
    assign done = (state_reg == S_OUT);

    always_comb
    begin
        result.interp_y = y_reg;
        result.product_xy = mul_reg[tli_pkg::FRAC_W +: tli_pkg::PROD_W];
        result.clamped = clamp_reg;
    end

    a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (item.op == tli_pkg::OP_QUERY)) |=> busy)
        else $error("query transaction did not raise busy");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (item.op == tli_pkg::OP_LOAD)) |=> (!busy && !done))
        else $error("load transaction produced activity");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("result strobe not followed by idle");

    a_interior_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.clamped == tli_pkg::CLAMP_NONE)) |->
            (down_reg ? ((y_reg <= y1_reg) && ((y1_reg - y_reg) <= dy_reg))
                      : ((y_reg >= y1_reg) && ((y_reg - y1_reg) <= dy_reg))))
        else $error("interpolated value outside its span");

endmodule

>>> rtl/tli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tli_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit VALUE_W bits.
`timescale 1ns / 1ps

module tli_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2*tli_pkg::VALUE_W-1:0] num,
    input  logic [tli_pkg::VALUE_W-1:0]   den,
    output logic [tli_pkg::VALUE_W-1:0]   quo,
    output logic                          done
);

    localparam int W = tli_pkg::VALUE_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     sh_reg, sh_next;
    logic [W-1:0]     den_reg, den_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    always_comb
    begin
        trial = {rem_reg, sh_reg[W-1]};
        diff = trial - {1'b0, den_reg};
        ge = (trial >= {1'b0, den_reg});

        cnt_next = cnt_reg;
        done_next = 1'b0;
        rem_next = rem_reg;
        sh_next = sh_reg;
        den_next = den_reg;

        if (start)
        begin
            // high half is below the divisor, so it seeds the remainder
            rem_next = num[2*W-1:W];
            sh_next = num[W-1:0];
            den_next = den;
            cnt_next = CNT_W'(W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            sh_next = {sh_reg[W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg <= sh_next;
        den_reg <= den_next;
    end

    assign quo = sh_reg;
    assign done = done_reg;

endmodule
